// File: sv/ycbcr_brightness_adjust_defines.svh
// assertion macros shared by the brightness adjust rtl
`ifndef YCBCR_BRIGHTNESS_ADJUST_DEFINES_SVH
`define YCBCR_BRIGHTNESS_ADJUST_DEFINES_SVH

// same-cycle implication, sampled on aclk, off while in reset
`define YBA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, off while in reset
`define YBA_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/yba_pkg.sv
// shared constants and types of the brightness adjust block
`default_nettype none

package yba_pkg;

    // fraction bits of the fixed-point coefficients
    localparam int DEF_COEF_FRAC_BITS = 14;

    // pixel channel and packed pixel widths
    localparam int CHAN_W     = 8;
    localparam int PIX_DATA_W = 3 * CHAN_W;

    // luma offset register
    localparam int                 OFFSET_W     = 8;
    localparam logic [OFFSET_W-1:0] OFFSET_RESET = 8'd30;

    // pipeline depth: products, sums, chroma products, sums, clamp
    localparam int NUM_STAGES = 5;

    // stage load enables from control to datapath
    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } yba_ctrl_t;

endpackage

`default_nettype wire

// File: sv/yba_datapath.sv
// five-stage fixed-point rgb to ycbcr, luma offset and back to rgb
`default_nettype none

module yba_datapath #(
    parameter int COEF_FRAC_BITS = yba_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                                 aclk,
    input  wire yba_pkg::yba_ctrl_t                   ctrl,
    input  wire logic        [yba_pkg::OFFSET_W-1:0]  luma_offset,
    input  wire logic        [yba_pkg::CHAN_W-1:0]    red_in,
    input  wire logic        [yba_pkg::CHAN_W-1:0]    green_in,
    input  wire logic        [yba_pkg::CHAN_W-1:0]    blue_in,
    output logic             [yba_pkg::CHAN_W-1:0]    red_out,
    output logic             [yba_pkg::CHAN_W-1:0]    green_out,
    output logic             [yba_pkg::CHAN_W-1:0]    blue_out
);

    localparam int F   = COEF_FRAC_BITS;
    localparam int CW  = F + 1;                  // unsigned coefficient
    localparam int P1W = CW + yba_pkg::CHAN_W;   // coefficient times channel
    localparam int YW  = F + 10;                 // signed luma
    localparam int CCW = F + 9;                  // signed chroma
    localparam int RW  = 2 * F + 11;             // signed reconstructed channel

    // coefficients, rounded half up
    localparam longint V_YR  = ((longint'(299)  << F) + 500) / 1000;
    localparam longint V_YG  = ((longint'(587)  << F) + 500) / 1000;
    localparam longint V_YB  = ((longint'(114)  << F) + 500) / 1000;
    localparam longint V_CBR = ((longint'(169)  << F) + 500) / 1000;
    localparam longint V_CBG = ((longint'(331)  << F) + 500) / 1000;
    localparam longint V_CBB = ((longint'(500)  << F) + 500) / 1000;
    localparam longint V_CRG = ((longint'(419)  << F) + 500) / 1000;
    localparam longint V_CRB = ((longint'(813)  << F) + 5000) / 10000;
    localparam longint V_RCR = ((longint'(1402) << F) + 500) / 1000;
    localparam longint V_GCR = ((longint'(714)  << F) + 500) / 1000;
    localparam longint V_GCB = ((longint'(344)  << F) + 500) / 1000;
    localparam longint V_BCB = ((longint'(1772) << F) + 500) / 1000;

    localparam logic [CW-1:0] K_YR  = CW'(V_YR);
    localparam logic [CW-1:0] K_YG  = CW'(V_YG);
    localparam logic [CW-1:0] K_YB  = CW'(V_YB);
    localparam logic [CW-1:0] K_CBR = CW'(V_CBR);
    localparam logic [CW-1:0] K_CBG = CW'(V_CBG);
    localparam logic [CW-1:0] K_HALF = CW'(V_CBB);
    localparam logic [CW-1:0] K_CRG = CW'(V_CRG);
    localparam logic [CW-1:0] K_CRB = CW'(V_CRB);

    // reconstruction coefficients as non-negative signed values
    localparam logic signed [CW:0] K_RCR = $signed({1'b0, CW'(V_RCR)});
    localparam logic signed [CW:0] K_GCR = $signed({1'b0, CW'(V_GCR)});
    localparam logic signed [CW:0] K_GCB = $signed({1'b0, CW'(V_GCB)});
    localparam logic signed [CW:0] K_BCB = $signed({1'b0, CW'(V_BCB)});

    // 255.0 with 2F fraction bits
    localparam logic signed [RW-1:0] CLAMP_TOP = $signed(RW'(255)) <<< (2 * F);

    // stage 1: coefficient times channel
    logic [P1W-1:0] p_yr_reg,  p_yg_reg,  p_yb_reg;
    logic [P1W-1:0] p_cbr_reg, p_cbg_reg, p_cbb_reg;
    logic [P1W-1:0] p_crr_reg, p_crg_reg, p_crb_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[0]) begin
            p_yr_reg  <= K_YR   * red_in;
            p_yg_reg  <= K_YG   * green_in;
            p_yb_reg  <= K_YB   * blue_in;
            p_cbr_reg <= K_CBR  * red_in;
            p_cbg_reg <= K_CBG  * green_in;
            p_cbb_reg <= K_HALF * blue_in;
            p_crr_reg <= K_HALF * red_in;
            p_crg_reg <= K_CRG  * green_in;
            p_crb_reg <= K_CRB  * blue_in;
        end
    end

    // stage 2: luma with offset, chroma sums
    logic signed [YW-1:0]  off_term;
    logic signed [YW-1:0]  y_next, cb_sum, cr_sum;
    logic signed [CCW-1:0] cb_next, cr_next;
    logic signed [YW-1:0]  y2_reg;
    logic signed [CCW-1:0] cb2_reg, cr2_reg;

    always_comb begin
        off_term = $signed(YW'($signed(luma_offset))) <<< F;
        y_next   = $signed({1'b0, p_yr_reg}) + $signed({1'b0, p_yg_reg})
                 + $signed({1'b0, p_yb_reg}) + off_term;
        cb_sum   = $signed({1'b0, p_cbb_reg}) - $signed({1'b0, p_cbr_reg})
                 - $signed({1'b0, p_cbg_reg});
        cr_sum   = $signed({1'b0, p_crr_reg}) - $signed({1'b0, p_crg_reg})
                 - $signed({1'b0, p_crb_reg});
        cb_next  = cb_sum[CCW-1:0];
        cr_next  = cr_sum[CCW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[1]) begin
            y2_reg  <= y_next;
            cb2_reg <= cb_next;
            cr2_reg <= cr_next;
        end
    end

    // stage 3: coefficient times chroma, luma carried along
    logic signed [RW-1:0] p_rcr_reg, p_gcr_reg, p_gcb_reg, p_bcb_reg;
    logic signed [YW-1:0] y3_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[2]) begin
            p_rcr_reg <= K_RCR * cr2_reg;
            p_gcr_reg <= K_GCR * cr2_reg;
            p_gcb_reg <= K_GCB * cb2_reg;
            p_bcb_reg <= K_BCB * cb2_reg;
            y3_reg    <= y2_reg;
        end
    end

    // stage 4: reconstructed channels with 2F fraction bits
    logic signed [RW-1:0] y_scaled;
    logic signed [RW-1:0] r_acc_next, g_acc_next, b_acc_next;
    logic signed [RW-1:0] r_acc_reg, g_acc_reg, b_acc_reg;

    always_comb begin
        y_scaled   = $signed(RW'(y3_reg)) <<< F;
        r_acc_next = y_scaled + p_rcr_reg;
        g_acc_next = y_scaled - p_gcr_reg - p_gcb_reg;
        b_acc_next = y_scaled + p_bcb_reg;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load[3]) begin
            r_acc_reg <= r_acc_next;
            g_acc_reg <= g_acc_next;
            b_acc_reg <= b_acc_next;
        end
    end

    // stage 5: clamp to 0..255 and keep the integer part
    function automatic logic [yba_pkg::CHAN_W-1:0] clamp_chan(
        input logic signed [RW-1:0] acc
    );
        logic [yba_pkg::CHAN_W-1:0] res;
        if (acc[RW-1]) begin
            res = '0;
        end else if (acc >= CLAMP_TOP) begin
            res = '1;
        end else begin
            res = acc[2*F +: yba_pkg::CHAN_W];
        end
        return res;
    endfunction

    logic [yba_pkg::CHAN_W-1:0] red_reg, green_reg, blue_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load[4]) begin
            red_reg   <= clamp_chan(r_acc_reg);
            green_reg <= clamp_chan(g_acc_reg);
            blue_reg  <= clamp_chan(b_acc_reg);
        end
    end

    assign red_out   = red_reg;
    assign green_out = green_reg;
    assign blue_out  = blue_reg;

endmodule

`default_nettype wire

// File: sv/ycbcr_brightness_adjust.sv
// top level: rgb brightness adjust through ycbcr with stream handshakes
//
//   channel  direction  payload                                   accepted when
//   s_       in         red_in, green_in, blue_in (24 bits)       s_tvalid & s_tready
//   m_       out        red_out, green_out, blue_out (24 bits)    m_tvalid & m_tready
//   cfg_     in         luma_offset (8 bits, signed)              cfg_valid & cfg_ready
//
// one pixel per cycle while s_tready is high; a pixel passes through five register
// stages, one each for channel products, ycbcr sums, chroma products, rgb sums and
// the clamp / output register.
// each stage has its own valid bit and holds while the stage after it is full,
// so input stalls only once all five stages hold pixels and m_tready is low.
// reset clears the valid bits and loads luma_offset with 30.
`default_nettype none

`include "ycbcr_brightness_adjust_defines.svh"

module ycbcr_brightness_adjust #(
    parameter int COEF_FRAC_BITS = yba_pkg::DEF_COEF_FRAC_BITS
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // input pixel
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [yba_pkg::PIX_DATA_W-1:0]     s_tdata,   // red_in, green_in, blue_in
    // adjusted pixel
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [yba_pkg::PIX_DATA_W-1:0]     m_tdata,   // red_out, green_out, blue_out
    // luma offset register write
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [yba_pkg::OFFSET_W-1:0]       cfg_data
);

    localparam int NS = yba_pkg::NUM_STAGES;
    localparam int CH = yba_pkg::CHAN_W;

    // luma offset register
    logic [yba_pkg::OFFSET_W-1:0] luma_offset_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_offset_reg <= yba_pkg::OFFSET_RESET;
        end else if (cfg_valid && cfg_ready) begin
            luma_offset_reg <= cfg_data;
        end
    end

    // stage valid bits and backpressure
    logic [NS-1:0]      valid_reg, valid_next, stage_rdy;
    yba_pkg::yba_ctrl_t ctrl;

    always_comb begin
        stage_rdy[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
        valid_next[0] = stage_rdy[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < NS; i++) begin
            valid_next[i] = stage_rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
        ctrl.load = stage_rdy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_rdy[0];
    assign m_tvalid = valid_reg[NS-1];

    // arithmetic pipeline
    logic [CH-1:0] red_out, green_out, blue_out;

    yba_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .luma_offset (luma_offset_reg),
        .red_in      (s_tdata[0*CH +: CH]),
        .green_in    (s_tdata[1*CH +: CH]),
        .blue_in     (s_tdata[2*CH +: CH]),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out)
    );

    assign m_tdata = {blue_out, green_out, red_out};

    // occupancy and stall checks
    logic s_acc, m_acc;

    assign s_acc = s_tvalid && s_tready;
    assign m_acc = m_tvalid && m_tready;

    `YBA_ASSERT_IMP(a_stall_only_when_full, !s_tready, (&valid_reg) && !m_tready, "input stalled with a free stage")
    `YBA_ASSERT_NXT(a_fill_on_request, s_acc && !m_acc, $countones(valid_reg) == $past($countones(valid_reg)) + 1, "occupancy did not grow")
    `YBA_ASSERT_NXT(a_drain_on_result, m_acc && !s_acc, $countones(valid_reg) + 1 == $past($countones(valid_reg)), "occupancy did not shrink")
    `YBA_ASSERT_NXT(a_steady_on_both, s_acc && m_acc, $countones(valid_reg) == $past($countones(valid_reg)), "occupancy changed in flow")

endmodule

`default_nettype wire
